// ===== src/svg_pkg.sv =====
`timescale 1ns / 1ps
// Package for the statevector gate engine: word types, op codes, sizes and
// the rounding/saturation helpers. Used by the engine and the checker.
package svg_pkg;

    localparam int MAX_AMPLITUDES = 1024;
    localparam int ADDR_W         = $clog2(MAX_AMPLITUDES);
    localparam int AMP_W          = 18;
    localparam int ENTRY_W        = 2 * AMP_W;
    localparam int SUM_W          = 37;
    localparam int ACC_W          = 24;
    localparam logic [3:0] QUBITS_RESET = 4'd10;

    localparam logic [2:0] KIND_INIT    = 3'd0;
    localparam logic [2:0] KIND_RX      = 3'd1;
    localparam logic [2:0] KIND_RY      = 3'd2;
    localparam logic [2:0] KIND_RZ      = 3'd3;
    localparam logic [2:0] KIND_CNOT    = 3'd4;
    localparam logic [2:0] KIND_MEASURE = 3'd5;

    localparam logic signed [AMP_W-1:0] AMP_ONE = 18'sd65536;
    localparam logic signed [AMP_W-1:0] AMP_MAX = 18'sd131071;
    localparam logic signed [AMP_W-1:0] AMP_MIN = -18'sd131072;
    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sd8388607;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -24'sd8388608;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         target_wire;
        logic [3:0]         control_wire;
        logic signed [15:0] cos_half;
        logic signed [15:0] sin_half;
    } t_op;

    typedef struct packed {
        logic [2:0]              done_kind;
        logic signed [ACC_W-1:0] expectation;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN, S_RDA, S_RDB, S_MUL, S_ACC, S_FIN, S_WRB, S_DONE
    } t_state;

    // round to nearest (tie up), drop 14 bits, saturate to an amplitude
    function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-15:0] q;
        begin
            t = v + SUM_W'(8192);
            q = (SUM_W-14)'(t >>> 14);
            if (q > (SUM_W-14)'(AMP_MAX))
                sat_amp = AMP_MAX;
            else if (q < $signed((SUM_W-14)'(AMP_MIN)))
                sat_amp = AMP_MIN;
            else
                sat_amp = q[AMP_W-1:0];
        end
    endfunction

    // |amp|^2 at 20 fractional bits; value is never negative
    function automatic logic signed [ACC_W-1:0] sat_prob(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-13:0] q;
        begin
            t = v + SUM_W'(2048);
            q = (SUM_W-12)'(t >>> 12);
            if (q > (SUM_W-12)'(ACC_MAX))
                sat_prob = ACC_MAX;
            else
                sat_prob = q[ACC_W-1:0];
        end
    endfunction

endpackage

// ===== src/statevector_gate_engine.sv =====
`timescale 1ns / 1ps
// Statevector gate engine: each op sweeps the amplitude RAM through one shared
// 18x18 multiplier. Init writes all 1024 RAM entries; rx and ry work per
// amplitude pair, rz and measure per amplitude, cnot per swapped pair, then a
// final scan, the result and idle. One word at a time; ready again once taken.
// Synchronous active-low reset: sequencer idle, qubits_in_use = 10.
// Amplitudes are undefined until an init word. Uses svg_pkg, svg_ram.
module statevector_gate_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  svg_pkg::t_op  i_op,
    output logic          o_valid,
    input  logic          i_stall,
    output svg_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_data
);
    localparam int AW = svg_pkg::ADDR_W;
    localparam int W  = svg_pkg::AMP_W;

    svg_pkg::t_state r_state, n_state;
    logic [3:0]   r_qubits;
    svg_pkg::t_op r_op;
    logic [AW:0]  r_i, n_i, r_len;
    logic [2:0]   r_k, n_k, r_pk;
    logic         r_pv;
    logic signed [W-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [2*W-1:0] r_prod;
    logic signed [svg_pkg::SUM_W-1:0] r_accp, sum;
    logic signed [W-1:0] r_res [4];
    logic signed [svg_pkg::ACC_W-1:0] r_p, r_macc;
    logic signed [svg_pkg::ACC_W+1:0] macc_next;

    logic [3:0]   nq;
    logic [AW:0]  len_new;
    logic         noop, pair, tbit, cbit, part;
    logic [AW-1:0] tstride, cstride, j_addr;
    logic         we;
    logic [AW-1:0] waddr, raddr;
    logic [svg_pkg::ENTRY_W-1:0] wdata, rdata;
    logic signed [W-1:0] c18, s18, ns18, mx, my;
    logic [2:0]   klast;

    svg_ram #(.WIDTH(svg_pkg::ENTRY_W), .DEPTH(svg_pkg::MAX_AMPLITUDES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_cfg_ready = 1'b1;

    // op decode on the input word
    always_comb begin
        nq = (r_qubits == 4'd0) ? 4'd1 : r_qubits;
        len_new = (nq >= 4'(AW)) ? (AW+1)'(svg_pkg::MAX_AMPLITUDES) : (AW+1)'(1) << nq;
        case (i_op.kind)
            svg_pkg::KIND_INIT, svg_pkg::KIND_MEASURE: noop = 1'b0;
            svg_pkg::KIND_RX, svg_pkg::KIND_RY:
                noop = (i_op.target_wire >= nq) || (i_op.target_wire >= 4'(AW));
            svg_pkg::KIND_RZ: noop = (i_op.target_wire >= nq);
            svg_pkg::KIND_CNOT:
                noop = (i_op.target_wire >= nq) || (i_op.control_wire >= nq) ||
                       (i_op.target_wire >= 4'(AW)) || (i_op.control_wire >= 4'(AW)) ||
                       (i_op.target_wire == i_op.control_wire);
            default: noop = 1'b1;
        endcase
    end

    // per-amplitude decode on the held op
    always_comb begin
        tstride = AW'(1) << r_op.target_wire;
        cstride = AW'(1) << r_op.control_wire;
        j_addr  = r_i[AW-1:0] | tstride;
        tbit    = |(r_i[AW-1:0] & tstride);
        cbit    = |(r_i[AW-1:0] & cstride);
        pair    = (r_op.kind == svg_pkg::KIND_RX) || (r_op.kind == svg_pkg::KIND_RY) ||
                  (r_op.kind == svg_pkg::KIND_CNOT);
        case (r_op.kind)
            svg_pkg::KIND_RX, svg_pkg::KIND_RY: part = !tbit;
            svg_pkg::KIND_CNOT:                 part = !tbit && cbit;
            default:                            part = 1'b1;
        endcase
        case (r_op.kind)
            svg_pkg::KIND_RZ:      klast = 3'd3;
            svg_pkg::KIND_MEASURE: klast = 3'd1;
            default:               klast = 3'd7;
        endcase
    end

    // multiplier operand select
    always_comb begin
        c18  = W'(r_op.cos_half);
        s18  = W'(r_op.sin_half);
        ns18 = -s18;
        mx = '0;
        my = '0;
        case (r_op.kind)
            svg_pkg::KIND_RX: begin
                case (r_k)
                    3'd0: begin mx = c18;  my = r_ar; end
                    3'd1: begin mx = s18;  my = r_bi; end
                    3'd2: begin mx = c18;  my = r_ai; end
                    3'd3: begin mx = ns18; my = r_br; end
                    3'd4: begin mx = s18;  my = r_ai; end
                    3'd5: begin mx = c18;  my = r_br; end
                    3'd6: begin mx = ns18; my = r_ar; end
                    default: begin mx = c18; my = r_bi; end
                endcase
            end
            svg_pkg::KIND_RY: begin
                case (r_k)
                    3'd0: begin mx = c18;  my = r_ar; end
                    3'd1: begin mx = ns18; my = r_br; end
                    3'd2: begin mx = c18;  my = r_ai; end
                    3'd3: begin mx = ns18; my = r_bi; end
                    3'd4: begin mx = s18;  my = r_ar; end
                    3'd5: begin mx = c18;  my = r_br; end
                    3'd6: begin mx = s18;  my = r_ai; end
                    default: begin mx = c18; my = r_bi; end
                endcase
            end
            svg_pkg::KIND_RZ: begin
                case (r_k)
                    3'd0: begin mx = c18; my = r_ar; end
                    3'd1: begin mx = tbit ? ns18 : s18; my = r_ai; end
                    3'd2: begin mx = tbit ? s18 : ns18; my = r_ar; end
                    default: begin mx = c18; my = r_ai; end
                endcase
            end
            svg_pkg::KIND_MEASURE: begin
                if (r_k[0]) begin
                    mx = r_ai; my = r_ai;
                end else begin
                    mx = r_ar; my = r_ar;
                end
            end
            default: begin mx = '0; my = '0; end
        endcase
    end

    assign sum = svg_pkg::SUM_W'(r_prod) + r_accp;

    always_comb begin
        macc_next = tbit ? (svg_pkg::ACC_W+2)'(r_macc) - (svg_pkg::ACC_W+2)'(r_p)
                         : (svg_pkg::ACC_W+2)'(r_macc) + (svg_pkg::ACC_W+2)'(r_p);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        we      = 1'b0;
        waddr   = r_i[AW-1:0];
        wdata   = '0;
        raddr   = r_i[AW-1:0];
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            svg_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_i = '0;
                    if (noop)
                        n_state = svg_pkg::S_DONE;
                    else if (i_op.kind == svg_pkg::KIND_INIT)
                        n_state = svg_pkg::S_INIT;
                    else
                        n_state = svg_pkg::S_SCAN;
                end
            end
            svg_pkg::S_INIT: begin
                we    = 1'b1;
                wdata = (r_i == '0) ? {svg_pkg::AMP_ONE, W'(0)} : '0;
                n_i   = r_i + 1'b1;
                if (&r_i[AW-1:0])
                    n_state = svg_pkg::S_DONE;
            end
            svg_pkg::S_SCAN: begin
                if (r_i == r_len)
                    n_state = svg_pkg::S_DONE;
                else if (part)
                    n_state = svg_pkg::S_RDA;
                else
                    n_i = r_i + 1'b1;
            end
            svg_pkg::S_RDA: begin
                raddr   = j_addr;
                n_k     = '0;
                n_state = pair ? svg_pkg::S_RDB : svg_pkg::S_MUL;
            end
            svg_pkg::S_RDB: begin
                n_k     = '0;
                n_state = (r_op.kind == svg_pkg::KIND_CNOT) ? svg_pkg::S_FIN : svg_pkg::S_MUL;
            end
            svg_pkg::S_MUL: begin
                n_k = r_k + 1'b1;
                if (r_k == klast)
                    n_state = svg_pkg::S_ACC;
            end
            svg_pkg::S_ACC: n_state = svg_pkg::S_FIN;
            svg_pkg::S_FIN: begin
                if (r_op.kind == svg_pkg::KIND_MEASURE) begin
                    n_i     = r_i + 1'b1;
                    n_state = svg_pkg::S_SCAN;
                end else begin
                    we    = 1'b1;
                    wdata = (r_op.kind == svg_pkg::KIND_CNOT) ? {r_br, r_bi}
                                                              : {r_res[0], r_res[1]};
                    if (pair) begin
                        n_state = svg_pkg::S_WRB;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = svg_pkg::S_SCAN;
                    end
                end
            end
            svg_pkg::S_WRB: begin
                we      = 1'b1;
                waddr   = j_addr;
                wdata   = (r_op.kind == svg_pkg::KIND_CNOT) ? {r_ar, r_ai}
                                                            : {r_res[2], r_res[3]};
                n_i     = r_i + 1'b1;
                n_state = svg_pkg::S_SCAN;
            end
            svg_pkg::S_DONE: begin
                o_valid = 1'b1;
                if (!i_stall)
                    n_state = svg_pkg::S_IDLE;
            end
            default: n_state = svg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= svg_pkg::S_IDLE;
            r_qubits <= svg_pkg::QUBITS_RESET;
            r_pv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == svg_pkg::S_MUL);
            if (i_cfg_valid && o_cfg_ready)
                r_qubits <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_k    <= n_k;
        r_pk   <= r_k;
        r_prod <= mx * my;
        if (r_state == svg_pkg::S_IDLE && i_valid) begin
            r_op   <= i_op;
            r_len  <= len_new;
            r_macc <= '0;
        end
        if (r_state == svg_pkg::S_RDA) begin
            r_ar <= rdata[2*W-1:W];
            r_ai <= rdata[W-1:0];
        end
        if (r_state == svg_pkg::S_RDB) begin
            r_br <= rdata[2*W-1:W];
            r_bi <= rdata[W-1:0];
        end
        if (r_pv) begin
            if (!r_pk[0]) begin
                r_accp <= svg_pkg::SUM_W'(r_prod);
            end else begin
                r_res[r_pk[2:1]] <= svg_pkg::sat_amp(sum);
                r_p              <= svg_pkg::sat_prob(sum);
            end
        end
        if (r_state == svg_pkg::S_FIN && r_op.kind == svg_pkg::KIND_MEASURE) begin
            if (macc_next > (svg_pkg::ACC_W+2)'(svg_pkg::ACC_MAX))
                r_macc <= svg_pkg::ACC_MAX;
            else if (macc_next < (svg_pkg::ACC_W+2)'(svg_pkg::ACC_MIN))
                r_macc <= svg_pkg::ACC_MIN;
            else
                r_macc <= macc_next[svg_pkg::ACC_W-1:0];
        end
    end

    assign o_res.done_kind   = r_op.kind;
    assign o_res.expectation = (r_op.kind == svg_pkg::KIND_MEASURE) ? r_macc : '0;
endmodule

// ===== src/svg_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module svg_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/svg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for statevector_gate_engine, bound to the top level.
// Depends on svg_pkg.
module svg_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input svg_pkg::t_res o_res
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("ready right after accepting a word");

    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");

    a_expzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.done_kind != svg_pkg::KIND_MEASURE |-> o_res.expectation == '0)
        else $error("nonzero expectation on a non-measure word");
endmodule

bind statevector_gate_engine svg_checker u_svg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
);
